// ----- design/fski_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fski_pkg - shared types and constants
// Default table size, hash multiplier halves, result record.
// ----------------------------------------------------------------------------
package fski_pkg;

  localparam int DEF_CAPACITY = 4096;

  // 64-bit golden-ratio multiplier, split into 32-bit halves
  localparam logic [31:0] GOLD_LO = 32'h7F4A7C15;
  localparam logic [31:0] GOLD_HI = 32'h9E3779B9;

  localparam int KEY_W   = 64;
  localparam int IDX_W   = 12;
  localparam int COUNT_W = 13;

  // control bits carried with each queued item
  typedef struct packed {
    logic clr;     // clear command
    logic lookup;  // well-formed item carrying a cookie
  } item_ctl_t;

  typedef struct packed {
    logic               index_valid;
    logic [IDX_W-1:0]   key_index;
    logic               is_new_key;
    logic [COUNT_W-1:0] entry_count;
    logic               table_full;
  } result_t;

endpackage

// ----- design/first_seen_key_index_table.sv -----
`timescale 1ns / 1ps
// The hash runs its multiply states and a mix state, then, for a table that
// is not a power of two, reduces four remainder bits per cycle; the probe
// engine takes the item, probes the one-port slot RAM with a read and a check
// state each, and loads the result register. The front takes one item at a
// time; the queue lets it hash the next during probes. Reset and every clear
// command sweep the slot RAM; full is held high after reset until it is done.
// ----------------------------------------------------------------------------
// first_seen_key_index_table - dense index assignment for client cookies
// Hash front, two-entry queue, linear-probe engine over an open-addressed
// slot RAM holding {used, cookie, index}.
// ----------------------------------------------------------------------------
module first_seen_key_index_table
  import fski_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                clk,
  input  logic                rst,
  // input queue side
  input  logic                push,
  output logic                full,
  input  logic                cmd,
  input  logic                is_malformed,
  input  logic                has_client_cookie,
  input  logic [KEY_W-1:0]    client_cookie,
  // result queue side
  output logic                empty,
  input  logic                pop,
  output logic                index_valid,
  output logic [IDX_W-1:0]    key_index,
  output logic                is_new_key,
  output logic [COUNT_W-1:0]  entry_count,
  output logic                table_full
);

  localparam int SW = $clog2(CAPACITY);
  localparam int QW = SW + KEY_W + 2;

  logic          front_busy;
  logic          init_busy;
  logic          go;
  logic          q_push, q_full, q_pop, q_empty;
  logic [QW-1:0] q_wdata, q_rdata;
  logic          res_valid;
  result_t       res;

  // no transfer in while the front is hashing or the power-up sweep runs
  assign full = front_busy || init_busy;
  assign go   = push && !full;

  fski_front #(
    .CAPACITY (CAPACITY)
  ) u_front (
    .clk               (clk),
    .rst               (rst),
    .go                (go),
    .cmd               (cmd),
    .is_malformed      (is_malformed),
    .has_client_cookie (has_client_cookie),
    .client_cookie     (client_cookie),
    .busy              (front_busy),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_data            (q_wdata)
  );

  fski_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .rd    (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  fski_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .init_busy (init_busy),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (pop)
  );

  // result register is the output queue head
  assign empty       = !res_valid;
  assign index_valid = res.index_valid;
  assign key_index   = res.key_index;
  assign is_new_key  = res.is_new_key;
  assign entry_count = res.entry_count;
  assign table_full  = res.table_full;

endmodule

// ----- design/fski_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fski_ram - generic single-port RAM
// One read or write per cycle, registered read data.
// ----------------------------------------------------------------------------
module fski_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- design/fski_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fski_front - item intake and hash
// Takes one item, hashes the cookie to its home slot with a shared 32x32
// multiplier, reduces it modulo the table size and hands it to the queue.
// ----------------------------------------------------------------------------
module fski_front
  import fski_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        go,
  input  logic                        cmd,
  input  logic                        is_malformed,
  input  logic                        has_client_cookie,
  input  logic [KEY_W-1:0]            client_cookie,
  output logic                        busy,
  input  logic                        q_full,
  output logic                        q_push,
  output logic [$clog2(CAPACITY)+KEY_W+1:0] q_data
);

  localparam int SW = $clog2(CAPACITY);
  localparam bit IS_POW2 = (CAPACITY & (CAPACITY - 1)) == 0;
  localparam logic [SW:0] CAP_R = (SW+1)'(CAPACITY);
  // remainder bits retired per cycle
  localparam int RDX = 4;

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_M0   = 3'd1;
  localparam logic [2:0] F_M1   = 3'd2;
  localparam logic [2:0] F_M2   = 3'd3;
  localparam logic [2:0] F_MIX  = 3'd4;
  localparam logic [2:0] F_RED  = 3'd5;
  localparam logic [2:0] F_PUSH = 3'd6;

  logic [2:0]       st;
  item_ctl_t        ctl;
  logic [KEY_W-1:0] key;
  logic [63:0]      lo;
  logic [31:0]      hi;
  logic [63:0]      h;
  logic [SW:0]      r;
  logic [5:0]       bitcnt;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [63:0] mixed_pre, mixed;
  logic [SW:0] r_shift, r_red;

  assign mul_a = (st == F_M1) ? key[63:32] : key[31:0];
  assign mul_b = (st == F_M2) ? GOLD_HI : GOLD_LO;
  assign prod  = mul_a * mul_b;

  assign mixed_pre = {hi + lo[63:32], lo[31:0]};
  assign mixed     = mixed_pre ^ (mixed_pre >> 29);

  // RDX remainder bits per cycle, each: r = (2r + bit) mod CAPACITY
  always_comb begin
    r_shift = '0;
    r_red   = r;
    for (int b = 0; b < RDX; b++) begin
      r_shift = {r_red[SW-1:0], h[63-b]};
      r_red   = (r_shift >= CAP_R) ? r_shift - CAP_R : r_shift;
    end
  end

  assign busy   = (st != F_IDLE);
  assign q_push = (st == F_PUSH) && !q_full;
  assign q_data = {ctl, key, r[SW-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= F_IDLE;
    end else begin
      case (st)
        F_IDLE: begin
          if (go) begin
            ctl.clr    <= cmd;
            ctl.lookup <= !cmd && !is_malformed && has_client_cookie;
            key        <= client_cookie;
            st <= (!cmd && !is_malformed && has_client_cookie) ? F_M0 : F_PUSH;
          end
        end
        F_M0: begin
          lo <= prod;
          st <= F_M1;
        end
        F_M1: begin
          hi <= prod[31:0];
          st <= F_M2;
        end
        F_M2: begin
          hi <= hi + prod[31:0];
          st <= F_MIX;
        end
        F_MIX: begin
          h      <= mixed;
          bitcnt <= '0;
          if (IS_POW2) begin
            r  <= {1'b0, mixed[SW-1:0]};
            st <= F_PUSH;
          end else begin
            r  <= '0;
            st <= F_RED;
          end
        end
        F_RED: begin
          r      <= r_red;
          h      <= h << RDX;
          bitcnt <= bitcnt + 6'd1;
          if (bitcnt == 6'd15) begin
            st <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!q_full) begin
            st <= F_IDLE;
          end
        end
        default: st <= F_IDLE;
      endcase
    end
  end

endmodule

// ----- design/fski_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fski_queue - two-entry decoupling queue
// Sits between the hash front and the probe engine.
// ----------------------------------------------------------------------------
module fski_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] slots [2];
  logic             wptr, rptr;
  logic [1:0]       cnt;

  assign full  = (cnt == 2'd2);
  assign empty = (cnt == 2'd0);
  assign rdata = slots[rptr];

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      slots[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (wr && !full) begin
        wptr <= !wptr;
      end
      if (rd && !empty) begin
        rptr <= !rptr;
      end
      cnt <= cnt + 2'((wr && !full) ? 1 : 0) - 2'((rd && !empty) ? 1 : 0);
    end
  end

endmodule

// ----- design/fski_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fski_back - probe engine and result register
// Linear probing through the slot RAM, insertion of new cookies, clearing
// sweeps, and the one-entry result register.
// ----------------------------------------------------------------------------
module fski_back
  import fski_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_empty,
  input  logic [$clog2(CAPACITY)+KEY_W+1:0] q_data,
  output logic                              q_pop,
  output logic                              init_busy,
  output logic                              res_valid,
  output result_t                           res,
  input  logic                              res_take
);

  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int RW = 1 + KEY_W + SW;
  localparam logic [CW-1:0] CAP_C   = CW'(CAPACITY);
  localparam logic [SW-1:0] LAST_SL = SW'(CAPACITY - 1);

  localparam logic [2:0] B_CLR  = 3'd0;
  localparam logic [2:0] B_IDLE = 3'd1;
  localparam logic [2:0] B_RD   = 3'd2;
  localparam logic [2:0] B_CK   = 3'd3;
  localparam logic [2:0] B_DONE = 3'd4;

  logic [2:0]       st;
  logic             clr_cmd;
  logic [SW-1:0]    pos;
  logic [SW-1:0]    probes;
  logic [CW-1:0]    count;
  logic [KEY_W-1:0] key;
  result_t          pend;

  item_ctl_t        q_ctl;
  logic [KEY_W-1:0] q_key;
  logic [SW-1:0]    q_slot;

  logic          ram_we;
  logic [RW-1:0] ram_wdata, ram_rdata;
  logic          r_used;
  logic [KEY_W-1:0] r_key;
  logic [SW-1:0] r_idx;
  logic          has_room;
  logic [31:0]   idx_wide, cnt_wide, cnt1_wide;

  assign {q_ctl, q_key, q_slot} = q_data;
  assign {r_used, r_key, r_idx} = ram_rdata;

  assign has_room  = (count < CAP_C);
  assign idx_wide  = 32'(r_idx);
  assign cnt_wide  = 32'(count);
  assign cnt1_wide = 32'(count) + 32'd1;

  assign q_pop     = (st == B_IDLE) && !q_empty;
  assign init_busy = (st == B_CLR) && !clr_cmd;

  assign ram_we    = (st == B_CLR) || ((st == B_CK) && !r_used && has_room);
  assign ram_wdata = (st == B_CLR) ? '0 : {1'b1, key, count[SW-1:0]};

  fski_ram #(
    .WIDTH (RW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (pos),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= B_CLR;
      clr_cmd   <= 1'b0;
      pos       <= '0;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_take) begin
        res_valid <= 1'b0;
      end
      case (st)
        B_CLR: begin
          pos <= (pos == LAST_SL) ? '0 : pos + 1'b1;
          if (pos == LAST_SL) begin
            count <= '0;
            pend  <= '0;
            st    <= clr_cmd ? B_DONE : B_IDLE;
          end
        end
        B_IDLE: begin
          if (!q_empty) begin
            key    <= q_key;
            probes <= '0;
            if (q_ctl.clr) begin
              clr_cmd <= 1'b1;
              pos     <= '0;
              st      <= B_CLR;
            end else if (!q_ctl.lookup) begin
              pend             <= '0;
              pend.entry_count <= cnt_wide[COUNT_W-1:0];
              st               <= B_DONE;
            end else begin
              pos <= q_slot;
              st  <= B_RD;
            end
          end
        end
        B_RD: begin
          st <= B_CK;
        end
        B_CK: begin
          pend             <= '0;
          pend.entry_count <= cnt_wide[COUNT_W-1:0];
          if (!r_used) begin
            if (has_room) begin
              pend.index_valid <= 1'b1;
              pend.key_index   <= cnt_wide[IDX_W-1:0];
              pend.is_new_key  <= 1'b1;
              pend.entry_count <= cnt1_wide[COUNT_W-1:0];
              count            <= count + 1'b1;
            end else begin
              pend.table_full <= 1'b1;
            end
            st <= B_DONE;
          end else if (r_key == key) begin
            pend.index_valid <= 1'b1;
            pend.key_index   <= idx_wide[IDX_W-1:0];
            st               <= B_DONE;
          end else if (probes == LAST_SL) begin
            pend.table_full <= 1'b1;
            st              <= B_DONE;
          end else begin
            pos    <= (pos == LAST_SL) ? '0 : pos + 1'b1;
            probes <= probes + 1'b1;
            st     <= B_RD;
          end
        end
        B_DONE: begin
          if (!res_valid || res_take) begin
            res       <= pend;
            res_valid <= 1'b1;
            clr_cmd   <= 1'b0;
            st        <= B_IDLE;
          end
        end
        default: st <= B_IDLE;
      endcase
    end
  end

  // occupancy never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CAP_C)
    else $error("entry count beyond capacity");

  // an insertion bumps the count by exactly one
  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (st == B_CK && !r_used && has_room) |=> count == $past(count) + 1'b1)
    else $error("insert did not advance count");

  // a refused or absent index never comes with an insertion
  a_res_flags: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res.table_full && res.index_valid) &&
                  (!res.is_new_key || res.index_valid))
    else $error("inconsistent result flags");

  // the queue is only drained while no lookup is in flight
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (st == B_IDLE) && !ram_we)
    else $error("queue popped while busy");

endmodule
